// ===== sv/scfla_pkg.sv =====
// Package with shared constants, types and helper functions of the size-class allocator.
package scfla_pkg;

	localparam int STORE_WORDS_DEF       = 65536;
	localparam int NUM_CLASSES_DEF       = 8;
	localparam int FIRST_OBJECT_WORD_DEF = 11;
	localparam int HEADER_WORDS          = 3;
	localparam int REQ_W                 = 16;
	localparam int NEED_W                = 20;
	localparam int LEN_W                 = 62;
	localparam int STATUS_W              = 2;
	localparam int OFFSET_W              = 19;
	localparam int GRANT_W               = 17;
	localparam int SPLIT_SLACK_BYTES     = 25;
	localparam int HDR_FREE_BIT          = 63;
	localparam int HDR_LAST_BIT          = 62;
	localparam int LINK_VALID_BIT        = 63;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_GRANTED = 2'd0;
	localparam status_t ST_NONE    = 2'd1;
	localparam status_t ST_CORRUPT = 2'd2;

	typedef enum logic [4:0] {
		S_INIT_HDR,
		S_INIT_LINK,
		S_INIT_TRL,
		S_IDLE,
		S_SEARCH,
		S_RD_HDR,
		S_CHECK,
		S_RD_LINK,
		S_LINK,
		S_W_RHDR,
		S_W_RTRL,
		S_W_RLINK,
		S_W_HDR,
		S_W_LINK,
		S_W_TRL,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		WR_NONE,
		WR_INIT_HDR,
		WR_INIT_LINK,
		WR_INIT_TRL,
		WR_RHDR,
		WR_RTRL,
		WR_RLINK,
		WR_HDR,
		WR_LINK,
		WR_TRL
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_HDR,
		RD_LINK
	} rd_sel_t;

	typedef struct packed {
		logic    ld_req;
		logic    search;
		logic    ld_hdr;
		logic    ld_link;
		logic    ld_out;
		status_t out_code;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic found;
		logic corrupt;
		logic split;
	} dp_stat_t;

	// Size class: index of the highest nonzero 10-bit group of a byte length.
	function automatic logic [2:0] class_of(input logic [LEN_W-1:0] b);
		logic [2:0] c;
		c = 3'd0;
		for (int i = 1; i < 6; i++) begin
			if (|b[10*i +: 10]) begin
				c = 3'(i);
			end
		end
		if (|b[LEN_W-1:60]) begin
			c = 3'd6;
		end
		return c;
	endfunction

endpackage

// ===== sv/scfla_req_if.sv =====
// Request channel interface carrying the payload size.
interface scfla_req_if;
	logic                          valid;
	logic                          ready;
	logic [scfla_pkg::REQ_W-1:0]   request_words;

	modport source (output valid, output request_words, input ready);
	modport sink   (input valid, input request_words, output ready);
endinterface

// ===== sv/scfla_rsp_if.sv =====
// Response channel interface carrying status, payload offset and granted length.
interface scfla_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [scfla_pkg::STATUS_W-1:0] status;
	logic [scfla_pkg::OFFSET_W-1:0] data_offset;
	logic [scfla_pkg::GRANT_W-1:0]  granted_words;

	modport source (output valid, output status, output data_offset, output granted_words,
		input ready);
	modport sink   (input valid, input status, input data_offset, input granted_words,
		output ready);
endinterface

// ===== sv/scfla_datapath.sv =====
// Datapath of the allocator: word store, class heads, working registers and result register.
module scfla_datapath #(
	parameter int STORE_WORDS       = scfla_pkg::STORE_WORDS_DEF,
	parameter int NUM_CLASSES       = scfla_pkg::NUM_CLASSES_DEF,
	parameter int FIRST_OBJECT_WORD = scfla_pkg::FIRST_OBJECT_WORD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scfla_pkg::dp_cmd_t             cmd,
	output scfla_pkg::dp_stat_t            stat,
	input  logic [scfla_pkg::REQ_W-1:0]    request_words,
	output logic [scfla_pkg::STATUS_W-1:0] status,
	output logic [scfla_pkg::OFFSET_W-1:0] data_offset,
	output logic [scfla_pkg::GRANT_W-1:0]  granted_words
);
	localparam int AW = $clog2(STORE_WORDS);
	localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam logic [31:0] STORE32 = 32'(STORE_WORDS);
	localparam logic [63:0] INIT_LEN = 64'(STORE_WORDS - FIRST_OBJECT_WORD) * 64'd8;

	logic [63:0] mem [STORE_WORDS];
	logic [63:0] rdata_q;

	logic [AW-1:0] head_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] headv_q;

	logic [scfla_pkg::NEED_W-1:0] need_q;
	logic [2:0]                   reqcls_q;
	logic [CW-1:0]                cls_q;
	logic [AW-1:0]                w_q;
	logic [63:0]                  hdr_q;
	logic                         split_q;
	logic [scfla_pkg::LEN_W-1:0]  rlen_q;

	// Word index sums stay below twice the store size, so one subtract wraps them.
	function automatic logic [AW-1:0] wrap(input logic [31:0] x);
		logic [31:0] y;
		y = (x >= STORE32) ? (x - STORE32) : x;
		return y[AW-1:0];
	endfunction

	logic [scfla_pkg::NEED_W-1:0] need_in;
	logic [scfla_pkg::LEN_W-1:0]  real_len, used_len, rd_real;
	logic [31:0]                  w32, rw32;
	logic [AW-1:0]                rw;
	logic [2:0]                   rc_raw;
	logic [CW-1:0]                rc, found_idx;
	logic                         found;
	logic [AW-1:0]                addr;
	logic [63:0]                  wdata;
	logic                         we, re;

	assign need_in = scfla_pkg::NEED_W'(({4'd0, request_words} + 20'(scfla_pkg::HEADER_WORDS))
		<< 3);
	assign real_len = hdr_q[scfla_pkg::LEN_W-1:0];
	assign used_len = split_q ? scfla_pkg::LEN_W'(need_q) : real_len;
	assign rd_real  = rdata_q[scfla_pkg::LEN_W-1:0];
	assign w32      = 32'(w_q);
	assign rw       = wrap(w32 + 32'(need_q >> 3));
	assign rw32     = 32'(rw);
	assign rc_raw   = scfla_pkg::class_of(rlen_q);
	assign rc       = (32'(rc_raw) >= 32'(NUM_CLASSES)) ? CW'(NUM_CLASSES - 1) : CW'(rc_raw);

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			if (!found && headv_q[k] && (k >= int'(reqcls_q))) begin
				found     = 1'b1;
				found_idx = CW'(k);
			end
		end
	end

	assign stat.found   = found;
	assign stat.corrupt = !rdata_q[scfla_pkg::HDR_FREE_BIT]
		|| (scfla_pkg::LEN_W'(need_q) > rd_real);
	assign stat.split   = split_q;

	always_comb begin
		addr  = '0;
		wdata = '0;
		we    = 1'b1;
		re    = 1'b0;
		unique case (cmd.wr_sel)
			scfla_pkg::WR_INIT_HDR: begin
				addr  = AW'(FIRST_OBJECT_WORD);
				wdata = INIT_LEN | (64'd1 << scfla_pkg::HDR_FREE_BIT)
					| (64'd1 << scfla_pkg::HDR_LAST_BIT);
			end
			scfla_pkg::WR_INIT_LINK: begin
				addr  = wrap(32'(FIRST_OBJECT_WORD + 1));
				wdata = '0;
			end
			scfla_pkg::WR_INIT_TRL: begin
				addr  = AW'(STORE_WORDS - 1);
				wdata = 64'(FIRST_OBJECT_WORD) * 64'd8;
			end
			scfla_pkg::WR_RHDR: begin
				addr  = rw;
				wdata = {1'b1, hdr_q[scfla_pkg::HDR_LAST_BIT], rlen_q};
			end
			scfla_pkg::WR_RTRL: begin
				addr  = wrap(rw32 + 32'(rlen_q >> 3) - 32'd1);
				wdata = 64'(rw) << 3;
			end
			scfla_pkg::WR_RLINK: begin
				addr  = wrap(rw32 + 32'd1);
				wdata = headv_q[rc] ? ((64'd1 << scfla_pkg::LINK_VALID_BIT) | 64'(head_q[rc]))
					: 64'd0;
			end
			scfla_pkg::WR_HDR: begin
				addr  = w_q;
				wdata = split_q ? 64'(need_q)
					: {1'b0, hdr_q[scfla_pkg::HDR_LAST_BIT], real_len};
			end
			scfla_pkg::WR_LINK: begin
				addr  = wrap(w32 + 32'd1);
				wdata = '0;
			end
			scfla_pkg::WR_TRL: begin
				addr  = wrap(w32 + 32'(used_len >> 3) - 32'd1);
				wdata = 64'(w_q) << 3;
			end
			default: begin
				we = 1'b0;
				unique case (cmd.rd_sel)
					scfla_pkg::RD_HDR: begin
						re   = 1'b1;
						addr = w_q;
					end
					scfla_pkg::RD_LINK: begin
						re   = 1'b1;
						addr = wrap(w32 + 32'd1);
					end
					default: begin
						re = 1'b0;
					end
				endcase
			end
		endcase
	end

	// Single-port word store with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				head_q[k] <= (k == NUM_CLASSES - 1) ? AW'(FIRST_OBJECT_WORD) : '0;
			end
			headv_q <= NUM_CLASSES'(1) << (NUM_CLASSES - 1);
		end else begin
			if (cmd.ld_link) begin
				head_q[cls_q]  <= rdata_q[AW-1:0];
				headv_q[cls_q] <= rdata_q[scfla_pkg::LINK_VALID_BIT];
			end
			// The remainder is pushed after the popped head has been replaced.
			if (cmd.wr_sel == scfla_pkg::WR_RLINK) begin
				head_q[rc]  <= rw;
				headv_q[rc] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			need_q   <= need_in;
			reqcls_q <= scfla_pkg::class_of(scfla_pkg::LEN_W'(need_in));
		end
		if (cmd.search) begin
			cls_q <= found_idx;
			w_q   <= head_q[found_idx];
		end
		if (cmd.ld_hdr) begin
			hdr_q   <= rdata_q;
			split_q <= rd_real >= (scfla_pkg::LEN_W'(need_q)
				+ scfla_pkg::LEN_W'(scfla_pkg::SPLIT_SLACK_BYTES));
		end
		if (cmd.ld_link) begin
			rlen_q <= real_len - scfla_pkg::LEN_W'(need_q);
		end
		if (cmd.ld_out) begin
			status <= cmd.out_code;
			if (cmd.out_code == scfla_pkg::ST_GRANTED) begin
				data_offset   <= scfla_pkg::OFFSET_W'((64'(w_q) << 3) + 64'd16);
				granted_words <= scfla_pkg::GRANT_W'(used_len >> 3);
			end else begin
				data_offset   <= '0;
				granted_words <= '0;
			end
		end
	end

endmodule

// ===== sv/scfla_ctrl.sv =====
// Controller state machine that sequences memory reads and writes for each request.
module scfla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  scfla_pkg::dp_stat_t  stat,
	output scfla_pkg::dp_cmd_t   cmd
);
	scfla_pkg::state_t  state_q, state_d;
	scfla_pkg::status_t res_q, res_d;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			scfla_pkg::S_INIT_HDR:  state_d = scfla_pkg::S_INIT_LINK;
			scfla_pkg::S_INIT_LINK: state_d = scfla_pkg::S_INIT_TRL;
			scfla_pkg::S_INIT_TRL:  state_d = scfla_pkg::S_IDLE;
			scfla_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = scfla_pkg::S_SEARCH;
				end
			end
			scfla_pkg::S_SEARCH: begin
				if (stat.found) begin
					state_d = scfla_pkg::S_RD_HDR;
				end else begin
					res_d   = scfla_pkg::ST_NONE;
					state_d = scfla_pkg::S_DONE;
				end
			end
			scfla_pkg::S_RD_HDR: state_d = scfla_pkg::S_CHECK;
			scfla_pkg::S_CHECK: begin
				if (stat.corrupt) begin
					res_d   = scfla_pkg::ST_CORRUPT;
					state_d = scfla_pkg::S_DONE;
				end else begin
					state_d = scfla_pkg::S_RD_LINK;
				end
			end
			scfla_pkg::S_RD_LINK: state_d = scfla_pkg::S_LINK;
			scfla_pkg::S_LINK: begin
				state_d = stat.split ? scfla_pkg::S_W_RHDR : scfla_pkg::S_W_HDR;
			end
			scfla_pkg::S_W_RHDR:  state_d = scfla_pkg::S_W_RTRL;
			scfla_pkg::S_W_RTRL:  state_d = scfla_pkg::S_W_RLINK;
			scfla_pkg::S_W_RLINK: state_d = scfla_pkg::S_W_HDR;
			scfla_pkg::S_W_HDR:   state_d = scfla_pkg::S_W_LINK;
			scfla_pkg::S_W_LINK:  state_d = scfla_pkg::S_W_TRL;
			scfla_pkg::S_W_TRL: begin
				res_d   = scfla_pkg::ST_GRANTED;
				state_d = scfla_pkg::S_DONE;
			end
			scfla_pkg::S_DONE: begin
				if (out_free) begin
					state_d = scfla_pkg::S_IDLE;
				end
			end
			default: state_d = scfla_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.out_code = res_q;
		cmd.rd_sel   = scfla_pkg::RD_NONE;
		cmd.wr_sel   = scfla_pkg::WR_NONE;
		in_ready     = 1'b0;
		unique case (state_q)
			scfla_pkg::S_INIT_HDR:  cmd.wr_sel = scfla_pkg::WR_INIT_HDR;
			scfla_pkg::S_INIT_LINK: cmd.wr_sel = scfla_pkg::WR_INIT_LINK;
			scfla_pkg::S_INIT_TRL:  cmd.wr_sel = scfla_pkg::WR_INIT_TRL;
			scfla_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_req = in_valid;
			end
			scfla_pkg::S_SEARCH:  cmd.search = 1'b1;
			scfla_pkg::S_RD_HDR:  cmd.rd_sel = scfla_pkg::RD_HDR;
			scfla_pkg::S_CHECK:   cmd.ld_hdr = 1'b1;
			scfla_pkg::S_RD_LINK: cmd.rd_sel = scfla_pkg::RD_LINK;
			scfla_pkg::S_LINK:    cmd.ld_link = 1'b1;
			scfla_pkg::S_W_RHDR:  cmd.wr_sel = scfla_pkg::WR_RHDR;
			scfla_pkg::S_W_RTRL:  cmd.wr_sel = scfla_pkg::WR_RTRL;
			scfla_pkg::S_W_RLINK: cmd.wr_sel = scfla_pkg::WR_RLINK;
			scfla_pkg::S_W_HDR:   cmd.wr_sel = scfla_pkg::WR_HDR;
			scfla_pkg::S_W_LINK:  cmd.wr_sel = scfla_pkg::WR_LINK;
			scfla_pkg::S_W_TRL:   cmd.wr_sel = scfla_pkg::WR_TRL;
			scfla_pkg::S_DONE:    cmd.ld_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scfla_pkg::S_INIT_HDR;
			res_q       <= scfla_pkg::ST_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/size_class_free_list_allocator_core.sv =====
// Top level of the size-class free-list allocator: controller plus datapath.
//
//  channel | role | payload
//  --------+------+-------------------------------------------
//  req     | in   | request_words
//  rsp     | out  | status, data_offset, granted_words
//
// A request searches the class heads and ends if no class has a block; else it reads the
// head's header, ends if it is corrupt, reads the link, writes the remainder when the block is
// split, then the block: the word store's single port takes two reads and up to six writes.
// After reset the controller writes the first object's header, link and trailer; no
// request is taken until they are done. The next request is taken while a finished
// result waits in the output register; a new result waits until that register is free.
module size_class_free_list_allocator_core #(
	parameter int STORE_WORDS       = scfla_pkg::STORE_WORDS_DEF,
	parameter int NUM_CLASSES       = scfla_pkg::NUM_CLASSES_DEF,
	parameter int FIRST_OBJECT_WORD = scfla_pkg::FIRST_OBJECT_WORD_DEF
) (
	input logic          clk,
	input logic          arst_n,
	scfla_req_if.sink    req,
	scfla_rsp_if.source  rsp
);
	scfla_pkg::dp_cmd_t  cmd;
	scfla_pkg::dp_stat_t stat;

	scfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	scfla_datapath #(
		.STORE_WORDS       (STORE_WORDS),
		.NUM_CLASSES       (NUM_CLASSES),
		.FIRST_OBJECT_WORD (FIRST_OBJECT_WORD)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.request_words (req.request_words),
		.status        (rsp.status),
		.data_offset   (rsp.data_offset),
		.granted_words (rsp.granted_words)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the size-class free-list allocator core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ITEMS   = 1650;
	localparam int DRAIN_START = 1400;
	localparam int CYCLE_LIMIT = 600000;
	localparam int CLASSES     = scfla_pkg::NUM_CLASSES_DEF;
	localparam int HEAP_WORDS  = scfla_pkg::STORE_WORDS_DEF;
	localparam int FIRST_WORD  = scfla_pkg::FIRST_OBJECT_WORD_DEF;
	localparam int REQ_W       = scfla_pkg::REQ_W;
	localparam int OFFSET_W    = scfla_pkg::OFFSET_W;
	localparam int GRANT_W     = scfla_pkg::GRANT_W;

	typedef struct packed {
		scfla_pkg::status_t   status;
		logic [OFFSET_W-1:0]  data_offset;
		logic [GRANT_W-1:0]   granted_words;
	} grant_t;

	typedef enum logic [1:0] {ROW_FIXED, ROW_FIT_SMALL, ROW_FIT_LARGE} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		int           arg;
		bit           typed;
		grant_t       result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	scfla_req_if req_ch();
	scfla_rsp_if rsp_ch();

	size_class_free_list_allocator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the allocator state.
	logic [63:0] heap_words [HEAP_WORDS];
	logic [31:0] list_head [CLASSES];
	bit          list_live [CLASSES];

	grant_t      pending_grants[$];
	int          error_count;
	int          cycle_count;
	bit          stim_done;
	stim_row_t   directed_rows[$];

	initial clk = 1'b0;

	always #5 clk = ~clk;

	function automatic int size_class(input logic [63:0] bytes);
		int c;
		c = 0;
		while (bytes >= 64'd1024) begin
			bytes = bytes / 64'd1024;
			c++;
		end
		return c;
	endfunction

	function automatic void heap_reset();
		logic [63:0] len;
		len = 64'(HEAP_WORDS - FIRST_WORD) * 8;
		foreach (heap_words[i]) heap_words[i] = '0;
		for (int c = 0; c < CLASSES; c++) begin
			list_head[c] = '0;
			list_live[c] = 1'b0;
		end
		heap_words[FIRST_WORD] = len | {2'b11, 62'b0};
		heap_words[FIRST_WORD + 1] = '0;
		heap_words[16'(FIRST_WORD + len / 8 - 1)] = 64'(FIRST_WORD) * 8;
		list_head[CLASSES-1] = FIRST_WORD;
		list_live[CLASSES-1] = 1'b1;
	endfunction

	// Pops the first live head from the request's class up, splitting off a roomy free remainder.
	function automatic grant_t allocate(input logic [REQ_W-1:0] words);
		grant_t      g;
		logic [63:0] need, hdr, blk_len, link, used, rest_len, w, rw;
		int          c, rc;
		g = '{status: scfla_pkg::ST_NONE, data_offset: '0, granted_words: '0};
		need = (64'(words) + scfla_pkg::HEADER_WORDS) * 8;
		for (c = size_class(need); c < CLASSES; c++) begin
			if (!list_live[c]) continue;
			w = 64'(list_head[c]);
			hdr = heap_words[w[15:0]];
			blk_len = {2'b00, hdr[61:0]};
			if (!hdr[63] || need > blk_len) begin
				g.status = scfla_pkg::ST_CORRUPT;
				break;
			end
			link = heap_words[16'(w + 1)];
			list_head[c] = link[31:0];
			list_live[c] = link[63];
			if (blk_len < need + scfla_pkg::SPLIT_SLACK_BYTES) begin
				used = blk_len;
				heap_words[w[15:0]] = used | {1'b0, hdr[62], 62'b0};
			end else begin
				rw = w + need / 8;
				rest_len = blk_len - need;
				rc = size_class(rest_len);
				if (rc >= CLASSES) rc = CLASSES - 1;
				heap_words[rw[15:0]] = rest_len | {1'b1, hdr[62], 62'b0};
				heap_words[16'(rw + rest_len / 8 - 1)] = rw * 8;
				heap_words[16'(rw + 1)] = list_live[rc] ? {1'b1, 31'b0, list_head[rc]} : 64'd0;
				list_head[rc] = 32'(rw[15:0]);
				list_live[rc] = 1'b1;
				used = need;
				heap_words[w[15:0]] = used;
			end
			heap_words[16'(w + 1)] = '0;
			heap_words[16'(w + used / 8 - 1)] = w * 8;
			g.status = scfla_pkg::ST_GRANTED;
			g.data_offset = OFFSET_W'(w * 8 + 16);
			g.granted_words = GRANT_W'(used / 8);
			break;
		end
		return g;
	endfunction

	// Request sized to take the current head of a class with a given number of spare words.
	function automatic logic [REQ_W-1:0] fit_request(input int c, input int spare);
		int blk_words;
		if (!list_live[c]) return REQ_W'($urandom_range(0, 40));
		blk_words = int'(heap_words[list_head[c][15:0]][61:0] / 8);
		if (blk_words - scfla_pkg::HEADER_WORDS - spare < 0) return '0;
		if (blk_words - scfla_pkg::HEADER_WORDS - spare > 65535) return 16'hFFFF;
		return REQ_W'(blk_words - scfla_pkg::HEADER_WORDS - spare);
	endfunction

	function automatic logic [REQ_W-1:0] resolve_row(input stim_row_t r);
		case (r.kind)
			ROW_FIT_SMALL: return fit_request(0, r.arg);
			ROW_FIT_LARGE: return fit_request(1, r.arg);
			default:       return REQ_W'(r.arg);
		endcase
	endfunction

	function automatic stim_row_t random_row(input int idx);
		stim_row_t r;
		int        pick;
		r.typed = 1'b0;
		r.result = '0;
		pick = $urandom_range(0, 99);
		r.kind = ROW_FIXED;
		if (idx < DRAIN_START) begin
			if (pick < 88) r.arg = $urandom_range(0, 40);
			else if (pick < 93) begin
				r.kind = ROW_FIT_SMALL;
				r.arg = $urandom_range(0, 5);
			end else if (pick < 94) r.arg = $urandom_range(41, 2000);
			else r.arg = $urandom_range(0, 65535);
		end else begin
			if (pick < 15) begin
				r.kind = ROW_FIT_LARGE;
				r.arg = (pick < 5) ? $urandom_range(0, 6) : $urandom_range(7, 150);
			end else if (pick < 50) begin
				r.kind = ROW_FIT_SMALL;
				r.arg = $urandom_range(0, 6);
			end else if (pick < 80) r.arg = $urandom_range(0, 40);
			else r.arg = $urandom_range(0, 65535);
		end
		return r;
	endfunction

	// Sender: bursts of transfers separated by random gaps.
	initial begin
		stim_row_t        row;
		logic [REQ_W-1:0] words;
		grant_t           predicted;
		int               burst_left;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.request_words = '0;
		stim_done = 1'b0;
		error_count = 0;
		heap_reset();
		directed_rows = '{
			'{ROW_FIXED, 0,     1'b1, '{scfla_pkg::ST_GRANTED, 19'd104, 17'd3}},
			'{ROW_FIXED, 65535, 1'b1, '{scfla_pkg::ST_CORRUPT, 19'd0, 17'd0}},
			'{ROW_FIXED, 65532, 1'b0, '0},
			'{ROW_FIXED, 1,     1'b0, '0},
			'{ROW_FIXED, 124,   1'b0, '0},
			'{ROW_FIXED, 125,   1'b0, '0},
			'{ROW_FIXED, 126,   1'b0, '0},
			'{ROW_FIXED, 32768, 1'b0, '0},
			'{ROW_FIXED, 21845, 1'b0, '0},
			'{ROW_FIXED, 2,     1'b0, '0},
			'{ROW_FIXED, 4660,  1'b0, '0},
			'{ROW_FIXED, 43690, 1'b0, '0},
			'{ROW_FIT_SMALL, 0, 1'b0, '0},
			'{ROW_FIXED, 7,     1'b0, '0}
		};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		burst_left = 0;
		for (int i = 0; i < directed_rows.size() + NUM_ITEMS; i++) begin
			row = (i < directed_rows.size()) ? directed_rows[i] : random_row(i);
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) != 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
			words = resolve_row(row);
			req_ch.valid <= 1'b1;
			req_ch.request_words <= words;
			do @(posedge clk); while (!req_ch.ready);
			predicted = allocate(words);
			pending_grants.push_back(row.typed ? row.result : predicted);
			@(negedge clk);
		end
		req_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: the stall pattern switches among four random modes.
	initial begin
		int mode;
		rsp_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(50, 300)) begin
				@(negedge clk);
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected transfer: status %0d offset %0d words %0d",
					rsp_ch.status, rsp_ch.data_offset, rsp_ch.granted_words);
				error_count++;
			end else begin
				want = pending_grants.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.data_offset !== want.data_offset) begin
					$error("data_offset: expected %0d, got %0d",
						want.data_offset, rsp_ch.data_offset);
					error_count++;
				end
				if (rsp_ch.granted_words !== want.granted_words) begin
					$error("granted_words: expected %0d, got %0d",
						want.granted_words, rsp_ch.granted_words);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (!(stim_done && pending_grants.size() == 0) && cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("size_class_free_list_allocator_core verification failed");
		end else begin
			repeat (40) @(posedge clk);
			if (error_count == 0) begin
				$display("size_class_free_list_allocator_core verification clean");
			end else begin
				$display("size_class_free_list_allocator_core verification failed");
			end
		end
		$finish;
	end

endmodule

// ===== size_class_free_list_allocator_core.f =====
sv/scfla_pkg.sv
sv/scfla_req_if.sv
sv/scfla_rsp_if.sv
sv/scfla_datapath.sv
sv/scfla_ctrl.sv
sv/size_class_free_list_allocator_core.sv
dv/tb_top.sv
